// ----- hdl/lsc_pkg.sv -----
`default_nettype none
package lsc_pkg;

	// CORDIC gain 0.6072529350 scaled by 2^32
	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

	localparam int ATAN_ENTRIES = 24;

	// atan(2^-i) in units of 2^-32 turn, truncated
	localparam logic [31:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
		32'h20000000, 32'h12e4051d, 32'h09fb385b, 32'h051111d4, 32'h028b0d43,
		32'h0145d7e1, 32'h00a2f61e, 32'h00517c55, 32'h0028be53, 32'h00145f2e,
		32'h000a2f98, 32'h000517cc, 32'h00028be6, 32'h000145f3, 32'h0000a2f9,
		32'h0000517c, 32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
		32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051
	};

	// configuration register indexes
	localparam logic [1:0] REG_ANGLE_START = 2'd0;
	localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
	localparam logic [1:0] REG_RANGE_LO    = 2'd2;
	localparam logic [1:0] REG_RANGE_HI    = 2'd3;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_ANGLE,
		TS_KICK,
		TS_WAIT
	} lsc_top_state_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_GAIN,
		CS_INIT,
		CS_STEP,
		CS_ROUND,
		CS_DONE
	} lsc_cordic_state_t;

	typedef struct packed {
		logic        start;
		logic [15:0] range;
		logic [15:0] angle;
	} lsc_cordic_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] x_mm;
		logic [16:0] y_mm;
	} lsc_cordic_rsp_t;

	// round half up to millimetres and clamp to +/-65535
	function automatic logic [16:0] to_mm(input logic signed [33:0] v);
		logic signed [34:0] t;
		logic signed [34:0] r;
		logic [16:0]        res;
		t = 35'(v) + 35'sd32768;
		r = t >>> 16;
		if (r > 35'sd65535) begin
			res = 17'h0ffff;
		end else if (r < -35'sd65535) begin
			res = 17'h10001;
		end else begin
			res = r[16:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/lsc_if.sv -----
`default_nettype none
interface lsc_beam_if;
	logic        valid;
	logic        ready;
	logic [15:0] range_mm;
	logic [15:0] beam_intensity;
	logic        end_of_scan;

	modport source (output valid, output range_mm, output beam_intensity,
		output end_of_scan, input ready);
	modport sink (input valid, input range_mm, input beam_intensity,
		input end_of_scan, output ready);
endinterface

interface lsc_point_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] x_mm;
	logic signed [16:0] y_mm;
	logic [15:0]        point_intensity;
	logic [10:0]        beam_number;
	logic               kept;
	logic [11:0]        kept_total;
	logic               scan_done;

	modport source (output valid, output x_mm, output y_mm, output point_intensity,
		output beam_number, output kept, output kept_total, output scan_done,
		input ready);
	modport sink (input valid, input x_mm, input y_mm, input point_intensity,
		input beam_number, input kept, input kept_total, input scan_done,
		output ready);
endinterface
`default_nettype wire

// ----- hdl/laser_scan_to_cartesian.sv -----
`default_nettype none
// Projects one lidar beam per transfer from polar to Cartesian form. The beam
// angle is angle_start + beam_number * angle_step (binary angle, 65536 per turn);
// a rotation CORDIC gives x_mm and y_mm rounded to millimetres and clamped to
// +/-65535. Beams are numbered from 0 within a scan and kept when the range is at
// or above the lower range bound and below the upper range bound (an empty window
// keeps nothing); both counters restart after a beam flagged end_of_scan.
// One beam at a time is in flight: after a transfer the block passes through the angle
// and kick states and the CORDIC gain, init, step, round and done states before it
// takes the next beam (stage counts above 24 act as 24); the single CORDIC step unit does
// one micro-rotation per cycle, and the hand-over is held back while an earlier
// point still waits for the sink. A finished point waits in the output register,
// so the next beam can be taken while it is pending.
// Configuration registers (index 0..3: angle_start, angle_step, lower range bound,
// upper range bound) are to be written only while no beam is in flight; the block does not enforce it.
module laser_scan_to_cartesian #(
	parameter int MAX_BEAMS     = 2048,
	parameter int CORDIC_STAGES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	lsc_beam_if.sink    beam,
	lsc_point_if.source point
);

	localparam int IDX_CAP_I  = (MAX_BEAMS - 1 < 2047) ? MAX_BEAMS - 1 : 2047;
	localparam int KEPT_CAP_I = (MAX_BEAMS < 4095) ? MAX_BEAMS : 4095;
	localparam logic [10:0] IDX_CAP  = 11'(IDX_CAP_I);
	localparam logic [11:0] KEPT_CAP = 12'(KEPT_CAP_I);

	lsc_pkg::lsc_top_state_t state_q, state_d;
	lsc_pkg::lsc_cordic_req_t req;
	lsc_pkg::lsc_cordic_rsp_t rsp;

	logic [15:0] angle_start_q;
	logic [15:0] angle_step_q;
	logic [15:0] rng_lo_q;
	logic [15:0] rng_hi_q;
	logic [10:0] beam_cnt_q;
	logic [11:0] kept_cnt_q;
	logic        out_valid_q;

	logic [15:0] range_q;
	logic [15:0] inten_q;
	logic        eos_q;
	logic [10:0] beam_q;
	logic        keep_q;
	logic [11:0] kept_total_q;
	logic [15:0] angle_q;

	logic [16:0] out_x_q;
	logic [16:0] out_y_q;
	logic [15:0] out_inten_q;
	logic [10:0] out_beam_q;
	logic        out_keep_q;
	logic [11:0] out_kept_q;
	logic        out_eos_q;

	logic        in_xfer;
	logic        out_xfer;
	logic        load;
	logic        keep;
	logic [11:0] kept_next;
	logic [15:0] ang_prod;

	assign in_xfer  = beam.valid && beam.ready;
	assign out_xfer = point.valid && point.ready;
	assign keep     = (beam.range_mm >= rng_lo_q) && (beam.range_mm < rng_hi_q);
	assign kept_next = (keep && (kept_cnt_q < KEPT_CAP)) ? kept_cnt_q + 1'b1 : kept_cnt_q;
	assign ang_prod = 16'(27'(beam_q) * 27'(angle_step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= '0;
			angle_step_q  <= '0;
			rng_lo_q      <= '0;
			rng_hi_q      <= 16'hffff;
		end else if (cfg_we) begin
			case (cfg_index)
				lsc_pkg::REG_ANGLE_START: angle_start_q <= cfg_data;
				lsc_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				lsc_pkg::REG_RANGE_LO:    rng_lo_q      <= cfg_data;
				lsc_pkg::REG_RANGE_HI:    rng_hi_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsc_pkg::TS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.range = range_q;
		req.angle = angle_q;
		load      = 1'b0;
		case (state_q)
			lsc_pkg::TS_IDLE: begin
				if (in_xfer) state_d = lsc_pkg::TS_ANGLE;
			end
			lsc_pkg::TS_ANGLE: state_d = lsc_pkg::TS_KICK;
			lsc_pkg::TS_KICK: begin
				req.start = 1'b1;
				state_d   = lsc_pkg::TS_WAIT;
			end
			lsc_pkg::TS_WAIT: begin
				// hold the result until the output register is free
				if (rsp.done && (!out_valid_q || point.ready)) begin
					load    = 1'b1;
					state_d = lsc_pkg::TS_IDLE;
				end
			end
			default: state_d = lsc_pkg::TS_IDLE;
		endcase
	end

	assign beam.ready = (state_q == lsc_pkg::TS_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_cnt_q  <= '0;
			kept_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (beam.end_of_scan) begin
					beam_cnt_q <= '0;
					kept_cnt_q <= '0;
				end else begin
					kept_cnt_q <= kept_next;
					if (beam_cnt_q < IDX_CAP) beam_cnt_q <= beam_cnt_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			range_q      <= beam.range_mm;
			inten_q      <= beam.beam_intensity;
			eos_q        <= beam.end_of_scan;
			beam_q       <= beam_cnt_q;
			keep_q       <= keep;
			kept_total_q <= kept_next;
		end
		if (state_q == lsc_pkg::TS_ANGLE) begin
			angle_q <= angle_start_q + ang_prod;
		end
		if (load) begin
			out_x_q     <= rsp.x_mm;
			out_y_q     <= rsp.y_mm;
			out_inten_q <= inten_q;
			out_beam_q  <= beam_q;
			out_keep_q  <= keep_q;
			out_kept_q  <= kept_total_q;
			out_eos_q   <= eos_q;
		end
	end

	lsc_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign point.valid           = out_valid_q;
	assign point.x_mm            = $signed(out_x_q);
	assign point.y_mm            = $signed(out_y_q);
	assign point.point_intensity = out_inten_q;
	assign point.beam_number     = out_beam_q;
	assign point.kept            = out_keep_q;
	assign point.kept_total      = out_kept_q;
	assign point.scan_done       = out_eos_q;

endmodule
`default_nettype wire

// ----- hdl/lsc_cordic.sv -----
`default_nettype none
module lsc_cordic #(
	parameter int STAGES = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire lsc_pkg::lsc_cordic_req_t req,
	output lsc_pkg::lsc_cordic_rsp_t rsp
);

	localparam int NSTEP  = (STAGES > lsc_pkg::ATAN_ENTRIES) ? lsc_pkg::ATAN_ENTRIES : STAGES;
	localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);

	lsc_pkg::lsc_cordic_state_t state_q, state_d;

	logic [STEP_W-1:0]  step_q;
	logic [15:0]        range_q;
	logic [15:0]        angle_q;
	logic [31:0]        x0_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [32:0] z_q;
	logic [16:0]        x_mm_q;
	logic [16:0]        y_mm_q;

	logic [47:0]        gain_prod;
	logic [31:0]        phase;
	logic               flip;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [32:0] atan_v;

	assign gain_prod = 48'(range_q) * 48'(lsc_pkg::GAIN_Q32);
	assign flip      = (angle_q[15:14] == 2'b01) || (angle_q[15:14] == 2'b10);
	assign phase     = {angle_q[15] ^ flip, angle_q[14:0], 16'b0};
	assign dx        = y_q >>> step_q;
	assign dy        = x_q >>> step_q;
	assign atan_v    = $signed({1'b0, lsc_pkg::ATAN_TAB[5'(step_q)]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsc_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lsc_pkg::CS_IDLE, lsc_pkg::CS_DONE: begin
				if (req.start) state_d = lsc_pkg::CS_GAIN;
			end
			lsc_pkg::CS_GAIN:  state_d = lsc_pkg::CS_INIT;
			lsc_pkg::CS_INIT:  state_d = lsc_pkg::CS_STEP;
			lsc_pkg::CS_STEP: begin
				if (step_q == LAST_STEP) state_d = lsc_pkg::CS_ROUND;
			end
			lsc_pkg::CS_ROUND: state_d = lsc_pkg::CS_DONE;
			default:           state_d = lsc_pkg::CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == lsc_pkg::CS_INIT) begin
			step_q <= '0;
		end else if (state_q == lsc_pkg::CS_STEP) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lsc_pkg::CS_IDLE, lsc_pkg::CS_DONE: begin
				if (req.start) begin
					range_q <= req.range;
					angle_q <= req.angle;
				end
			end
			lsc_pkg::CS_GAIN: x0_q <= gain_prod[47:16];
			lsc_pkg::CS_INIT: begin
				// left half-plane: turn by half a turn and negate the start vector
				x_q <= flip ? -$signed({2'b00, x0_q}) : $signed({2'b00, x0_q});
				y_q <= '0;
				z_q <= $signed({phase[31], phase});
			end
			lsc_pkg::CS_STEP: begin
				if (!z_q[32]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_v;
				end
			end
			lsc_pkg::CS_ROUND: begin
				x_mm_q <= lsc_pkg::to_mm(x_q);
				y_mm_q <= lsc_pkg::to_mm(y_q);
			end
			default: ;
		endcase
	end

	assign rsp.done = (state_q == lsc_pkg::CS_DONE);
	assign rsp.x_mm = x_mm_q;
	assign rsp.y_mm = y_mm_q;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;

	localparam int MAX_BEAMS     = 2048;
	localparam int CORDIC_STAGES = 16;
	localparam int IDX_CAP       = (MAX_BEAMS - 1 < 2047) ? MAX_BEAMS - 1 : 2047;
	localparam int KEPT_CAP      = (MAX_BEAMS < 4095) ? MAX_BEAMS : 4095;
	localparam int STAGE_COUNT   = (CORDIC_STAGES < lsc_pkg::ATAN_ENTRIES) ?
		CORDIC_STAGES : lsc_pkg::ATAN_ENTRIES;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic [15:0] range;
		logic [15:0] inten;
		logic        eos;
	} beam_t;

	typedef struct packed {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic [15:0]        inten;
		logic [10:0]        num;
		logic               kept;
		logic [11:0]        total;
		logic               done;
	} point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	lsc_beam_if  beam ();
	lsc_point_if point ();

	laser_scan_to_cartesian #(
		.MAX_BEAMS     (MAX_BEAMS),
		.CORDIC_STAGES (CORDIC_STAGES)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.beam      (beam),
		.point     (point)
	);

	always #5 clk = ~clk;

	beam_t       beam_backlog [$];
	point_t      points_due [$];
	int unsigned src_idle_pct = 28;
	int unsigned snk_idle_pct = 28;
	int          errors = 0;
	int          cycles = 0;

	// shadow of the block's registers and scan counters
	logic [15:0] sh_start, sh_step, sh_min, sh_max;
	logic [10:0] sh_beam;
	logic [11:0] sh_kept;

	function automatic logic signed [16:0] round_mm(input longint v);
		longint r;
		r = (v + 32768) >>> 16;
		if (r > 65535)
			r = 65535;
		if (r < -65535)
			r = -65535;
		return 17'(r);
	endfunction

	function automatic void cordic_xy(input logic [15:0] r, input logic [15:0] ang,
		output logic signed [16:0] xo, output logic signed [16:0] yo);
		logic [31:0] phase;
		longint      x, y, z, dx, dy;
		phase = {ang, 16'h0000};
		x = longint'((64'(r) * 64'(lsc_pkg::GAIN_Q32)) >> 16);
		y = 0;
		// fold the left half-plane onto the right one
		if (phase[31:30] == 2'b01 || phase[31:30] == 2'b10) begin
			phase[31] = ~phase[31];
			x = -x;
		end
		z = longint'($signed(phase));
		for (int i = 0; i < STAGE_COUNT; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(lsc_pkg::ATAN_TAB[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(lsc_pkg::ATAN_TAB[i]);
			end
		end
		xo = round_mm(x);
		yo = round_mm(y);
	endfunction

	function automatic point_t predict_point(input beam_t b);
		logic [15:0] ang;
		logic        keep;
		point_t      p;
		ang = sh_start + sh_beam * sh_step;
		keep = (b.range >= sh_min) && (b.range < sh_max);
		cordic_xy(b.range, ang, p.x, p.y);
		if (keep && sh_kept < KEPT_CAP)
			sh_kept = sh_kept + 1'b1;
		p.inten = b.inten;
		p.num = sh_beam;
		p.kept = keep;
		p.total = sh_kept;
		p.done = b.eos;
		if (b.eos) begin
			sh_beam = '0;
			sh_kept = '0;
		end else if (sh_beam < IDX_CAP) begin
			sh_beam = sh_beam + 1'b1;
		end
		return p;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// beam driver
	always @(posedge clk) begin
		beam_t b;
		if (arst_n) begin
			if (!beam.valid || beam.ready) begin
				if (beam_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					b = beam_backlog.pop_front();
					beam.valid <= 1'b1;
					beam.range_mm <= b.range;
					beam.beam_intensity <= b.inten;
					beam.end_of_scan <= b.eos;
				end else begin
					beam.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			point.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// monitor: predict on each beam transfer, check each point transfer
	always @(posedge clk) begin
		point_t e;
		if (arst_n) begin
			if (beam.valid && beam.ready)
				points_due.push_back(predict_point(beam_t'{beam.range_mm,
					beam.beam_intensity, beam.end_of_scan}));
			if (point.valid && point.ready) begin
				if (points_due.size() == 0) begin
					$error("unexpected point: x_mm %0d y_mm %0d beam_number %0d",
						point.x_mm, point.y_mm, point.beam_number);
					errors++;
				end else begin
					e = points_due.pop_front();
					check_field("x_mm", e.x, point.x_mm);
					check_field("y_mm", e.y, point.y_mm);
					check_field("point_intensity", e.inten, point.point_intensity);
					check_field("beam_number", e.num, point.beam_number);
					check_field("kept", e.kept, point.kept);
					check_field("kept_total", e.total, point.kept_total);
					check_field("scan_done", e.done, point.scan_done);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[laser_scan_to_cartesian] ERROR");
			$finish;
		end
	end

	task automatic add_beam(input logic [15:0] r, input logic [15:0] i, input logic e);
		beam_backlog.push_back(beam_t'{r, i, e});
	endtask

	// hold until every beam has gone through and every point has come back
	task automatic drain();
		do
			@(negedge clk);
		while (beam_backlog.size() != 0 || beam.valid || points_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			lsc_pkg::REG_ANGLE_START: sh_start = val;
			lsc_pkg::REG_ANGLE_STEP:  sh_step = val;
			lsc_pkg::REG_RANGE_LO:    sh_min = val;
			lsc_pkg::REG_RANGE_HI:    sh_max = val;
			default: ;
		endcase
	endtask

	task automatic set_window(input logic [15:0] a0, input logic [15:0] da,
		input logic [15:0] rmin, input logic [15:0] rmax);
		write_reg(lsc_pkg::REG_ANGLE_START, a0);
		write_reg(lsc_pkg::REG_ANGLE_STEP, da);
		write_reg(lsc_pkg::REG_RANGE_LO, rmin);
		write_reg(lsc_pkg::REG_RANGE_HI, rmax);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_window();
		int unsigned u, v, sel;
		logic [15:0] da;
		u = $urandom_range(0, 65535);
		v = $urandom_range(0, 65535);
		sel = $urandom_range(9);
		if ($urandom_range(3) == 0)
			da = 16'($urandom);
		else
			da = 16'($urandom_range(0, 800) - 400);
		if (sel == 0)
			set_window(16'($urandom), da, 16'h0000, 16'hFFFF);
		else if (sel == 1)
			set_window(16'($urandom), da, 16'(u > v ? u : v), 16'(u > v ? v : u));
		else
			set_window(16'($urandom), da, 16'(u < v ? u : v), 16'(u < v ? v : u));
	endtask

	// four in ten near the window edges or the field extremes, the rest uniform
	function automatic logic [15:0] pick_range();
		int sel, r;
		sel = $urandom_range(9);
		if (sel < 3) begin
			r = ($urandom_range(1) ? int'(sh_min) : int'(sh_max)) + $urandom_range(2) - 1;
			if (r < 0)
				r = 0;
			if (r > 65535)
				r = 65535;
		end else if (sel == 3) begin
			r = $urandom_range(1) ? 65535 : 0;
		end else begin
			r = $urandom_range(0, 65535);
		end
		return 16'(r);
	endfunction

	initial begin
		int n, len;
		beam.valid = 1'b0;
		beam.range_mm = '0;
		beam.beam_intensity = '0;
		beam.end_of_scan = 1'b0;
		point.ready = 1'b0;
		sh_start = '0;
		sh_step = '0;
		sh_min = '0;
		sh_max = 16'hFFFF;
		sh_beam = '0;
		sh_kept = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window: the top range lies just outside it
		add_beam(16'd0, 16'h0000, 1'b0);
		add_beam(16'hFFFF, 16'hFFFF, 1'b0);
		add_beam(16'hFFFE, 16'h5A5A, 1'b1);
		drain();

		// eight beams round a full turn starting at a quarter, window edges
		set_window(16'd16384, 16'd8192, 16'd100, 16'd1000);
		add_beam(16'd99, 16'h0001, 1'b0);
		add_beam(16'd100, 16'h8000, 1'b0);
		add_beam(16'd500, 16'h1234, 1'b0);
		add_beam(16'd999, 16'hFFFE, 1'b0);
		add_beam(16'd1000, 16'h7FFF, 1'b0);
		add_beam(16'hFFFF, 16'hA5A5, 1'b0);
		add_beam(16'd0, 16'h00FF, 1'b0);
		add_beam(16'd1, 16'hFF00, 1'b1);
		drain();

		// empty window, extreme angles
		set_window(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
		add_beam(16'hFFFF, 16'h0F0F, 1'b0);
		add_beam(16'd0, 16'hF0F0, 1'b0);
		add_beam(16'd40000, 16'h3C3C, 1'b0);
		add_beam(16'd12345, 16'hC3C3, 1'b1);
		drain();

		set_window(16'h7FFF, 16'h8000, 16'd0, 16'hFFFF);
		add_beam(16'hFFFF, 16'h0000, 1'b0);
		add_beam(16'hFFFE, 16'hFFFF, 1'b0);
		add_beam(16'd32768, 16'h5555, 1'b0);
		add_beam(16'd7, 16'hAAAA, 1'b1);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			random_window();
			src_idle_pct = (ph == 5) ? 0 : 28;
			snk_idle_pct = (ph == 5) ? 0 : 28;
			n = 0;
			while (n < 75) begin
				len = $urandom_range(1, 30);
				for (int j = 0; j < len; j++) begin
					add_beam(pick_range(), 16'($urandom),
						(j == len - 1) || ($urandom_range(19) == 0));
					n++;
				end
			end
			drain();
		end

		if (errors == 0 && points_due.size() == 0) begin
			$display("[laser_scan_to_cartesian] OK");
		end else begin
			$display("[laser_scan_to_cartesian] ERROR");
		end
		$finish;
	end

endmodule
